@@ rtl/bin_norm_pkg.sv @@
// ----------------------------------------------------------------------------
// Binarized image normalizer package
// Shared constants, register indexes, status codes and the read-info struct.
// ----------------------------------------------------------------------------
package bin_norm_pkg;

  // Default frame store geometry
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONBW_RATIO    = 3'd4;

  // Register field widths
  localparam int DIM_CFG_W = 10;
  localparam int GAP_W     = 9;
  localparam int PIX_W     = 8;
  localparam int RATIO_W   = 16;
  localparam int STATUS_W  = 2;

  // Register reset values
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST     = 10'd512;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST    = 10'd512;
  localparam logic [GAP_W-1:0]     GAP_RST       = 9'd1;
  localparam logic [PIX_W-1:0]     THRESHOLD_RST = 8'd128;
  localparam logic [RATIO_W-1:0]   RATIO_RST     = 16'd256;

  // Pixel levels
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_KEPT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG    = 2'd3;

  // Per-read control carried from the address stage to the fix-up stage
  typedef struct packed {
    logic             valid;
    logic             inner;
    logic             last;
    logic             binarized;
    logic             invert;
    logic             wrong;
    logic [PIX_W-1:0] threshold;
  } rd_info_t;

endpackage

@@ rtl/bin_norm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bin_norm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bin_norm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Binarized image normalizer control stage
// Config registers, pixel counters, load and read positions, store
// addressing and per-read frame status.
// ----------------------------------------------------------------------------
module bin_norm_ctrl #(
  parameter int MAX_WIDTH  = bin_norm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bin_norm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      accept,
  input  logic                                      in_mode,
  input  logic [bin_norm_pkg::PIX_W-1:0]            in_pixel,
  input  logic                                      in_frame_start,
  input  logic                                      cfg_we,
  input  logic [bin_norm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bin_norm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                      ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   ram_waddr,
  output logic [bin_norm_pkg::PIX_W-1:0]            ram_wdata,
  output logic                                      ram_re,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   ram_raddr,
  output bin_norm_pkg::rd_info_t                    info
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XSW   = ((WW > bin_norm_pkg::GAP_W) ? WW : bin_norm_pkg::GAP_W) + 1;
  localparam int YSW   = ((HW > bin_norm_pkg::GAP_W) ? HW : bin_norm_pkg::GAP_W) + 1;
  localparam int CMPW  = CW + bin_norm_pkg::RATIO_W;

  // Configuration registers
  logic [bin_norm_pkg::DIM_CFG_W-1:0] width_r, height_r;
  logic [bin_norm_pkg::GAP_W-1:0]     gap_r;
  logic [bin_norm_pkg::PIX_W-1:0]     thr_r;
  logic [bin_norm_pkg::RATIO_W-1:0]   ratio_r;

  // Counters and positions
  logic [CW-1:0] black_r, black_nxt;
  logic [CW-1:0] white_r, white_nxt;
  logic [CW-1:0] gray_r, gray_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  bin_norm_pkg::rd_info_t info_r, info_nxt;

  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [WW+HW-1:0] total_prod;
  logic [CW-1:0]    total;
  logic [CW-1:0]    pos_base;
  logic [CW-1:0]    black_base, white_base, gray_base;
  logic             store_ok;
  logic             oob;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic [YW+WW-1:0] row_base;
  logic             x_last, y_last;
  logic             inner;
  logic [CW:0]      bw_sum;
  logic [CMPW-1:0]  weighted;
  logic             binarized;

  // Clamp the frame dimensions: zero acts as one, oversize as the maximum
  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_r);
    end
  end

  assign total_prod = (WW+HW)'(eff_w) * (WW+HW)'(eff_h);
  assign total      = CW'(total_prod);

  // Load side
  assign pos_base   = in_frame_start ? '0 : pos_r;
  assign black_base = in_frame_start ? '0 : black_r;
  assign white_base = in_frame_start ? '0 : white_r;
  assign gray_base  = in_frame_start ? '0 : gray_r;
  assign store_ok   = pos_base < total;

  // Read side: restart at the origin when the position left the frame
  assign oob = (WW'(col_r) >= eff_w) || (HW'(row_r) >= eff_h);
  assign x   = oob ? '0 : col_r;
  assign y   = oob ? '0 : row_r;

  assign row_base = (YW+WW)'(y) * (YW+WW)'(eff_w);
  assign x_last   = (WW'(x) == eff_w - WW'(1));
  assign y_last   = (HW'(y) == eff_h - HW'(1));

  assign inner = (XSW'(x) > XSW'(gap_r)) && (YSW'(y) > YSW'(gap_r)) &&
                 (XSW'(x) + XSW'(gap_r) < XSW'(eff_w)) &&
                 (YSW'(y) + YSW'(gap_r) < YSW'(eff_h));

  // Frame status from the counts seen at this read
  assign bw_sum    = (CW+1)'(black_r) + (CW+1)'(white_r);
  assign weighted  = CMPW'(ratio_r) * CMPW'(gray_r);
  assign binarized = weighted < CMPW'({bw_sum, 8'h00});

  always_comb begin
    black_nxt = black_r;
    white_nxt = white_r;
    gray_nxt  = gray_r;
    pos_nxt   = pos_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    info_nxt  = '0;
    if (accept && !in_mode) begin
      black_nxt = black_base;
      white_nxt = white_base;
      gray_nxt  = gray_base;
      pos_nxt   = pos_base;
      if (in_frame_start) begin
        col_nxt = '0;
        row_nxt = '0;
      end
      if (store_ok) begin
        pos_nxt = pos_base + CW'(1);
        if (in_pixel == bin_norm_pkg::PIX_BLACK) begin
          black_nxt = black_base + CW'(1);
        end else if (in_pixel == bin_norm_pkg::PIX_WHITE) begin
          white_nxt = white_base + CW'(1);
        end else begin
          gray_nxt = gray_base + CW'(1);
        end
      end
    end else if (accept && in_mode) begin
      if (x_last) begin
        col_nxt = '0;
        row_nxt = y_last ? '0 : y + YW'(1);
      end else begin
        col_nxt = x + XW'(1);
        row_nxt = y;
      end
      info_nxt.valid     = 1'b1;
      info_nxt.inner     = inner;
      info_nxt.last      = x_last && y_last;
      info_nxt.binarized = binarized;
      info_nxt.invert    = (CW+1)'(black_r) > {white_r, 1'b0};
      info_nxt.wrong     = (white_r == '0);
      info_nxt.threshold = thr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bin_norm_pkg::WIDTH_RST;
      height_r <= bin_norm_pkg::HEIGHT_RST;
      gap_r    <= bin_norm_pkg::GAP_RST;
      thr_r    <= bin_norm_pkg::THRESHOLD_RST;
      ratio_r  <= bin_norm_pkg::RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bin_norm_pkg::CFG_FRAME_WIDTH:    width_r  <= cfg_wdata[bin_norm_pkg::DIM_CFG_W-1:0];
        bin_norm_pkg::CFG_FRAME_HEIGHT:   height_r <= cfg_wdata[bin_norm_pkg::DIM_CFG_W-1:0];
        bin_norm_pkg::CFG_FRAME_GAP:      gap_r    <= cfg_wdata[bin_norm_pkg::GAP_W-1:0];
        bin_norm_pkg::CFG_GRAY_THRESHOLD: thr_r    <= cfg_wdata[bin_norm_pkg::PIX_W-1:0];
        bin_norm_pkg::CFG_NONBW_RATIO:    ratio_r  <= cfg_wdata[bin_norm_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= '0;
      white_r <= '0;
      gray_r  <= '0;
      pos_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      info_r  <= '0;
    end else begin
      black_r <= black_nxt;
      white_r <= white_nxt;
      gray_r  <= gray_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      info_r  <= info_nxt;
    end
  end

  assign ram_we    = accept && !in_mode && store_ok;
  assign ram_waddr = AW'(pos_base);
  assign ram_wdata = in_pixel;
  assign ram_re    = accept && in_mode;
  assign ram_raddr = AW'(row_base) + AW'(x);
  assign info      = info_r;

endmodule

@@ rtl/bin_norm_fix.sv @@
// ----------------------------------------------------------------------------
// Binarized image normalizer fix-up stage
// When the frame is binarized, cleans gray pixels and applies inversion;
// the result is registered in every case.
module bin_norm_fix (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bin_norm_pkg::rd_info_t               info,
  input  logic [bin_norm_pkg::PIX_W-1:0]       rd_pixel,
  output logic                                 out_valid,
  output logic [bin_norm_pkg::PIX_W-1:0]       out_pixel_out,
  output logic [bin_norm_pkg::STATUS_W-1:0]    out_status,
  output logic                                 out_last
);

  logic                              valid_r;
  logic [bin_norm_pkg::PIX_W-1:0]    pixel_r, pixel_nxt;
  logic [bin_norm_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                              last_r;
  logic [bin_norm_pkg::PIX_W-1:0]    fixed;
  logic                              is_gray;

  assign is_gray = (rd_pixel != bin_norm_pkg::PIX_BLACK) &&
                   (rd_pixel != bin_norm_pkg::PIX_WHITE);

  always_comb begin
    fixed = rd_pixel;
    if (is_gray) begin
      fixed = (info.inner && (rd_pixel < info.threshold)) ? bin_norm_pkg::PIX_BLACK
                                                          : bin_norm_pkg::PIX_WHITE;
    end
  end

  always_comb begin
    pixel_nxt  = rd_pixel;
    status_nxt = bin_norm_pkg::ST_UNCHANGED;
    if (info.binarized) begin
      pixel_nxt  = fixed;
      status_nxt = bin_norm_pkg::ST_KEPT;
      if (info.invert) begin
        if (info.wrong) begin
          status_nxt = bin_norm_pkg::ST_WRONG;
        end else begin
          status_nxt = bin_norm_pkg::ST_INVERTED;
          pixel_nxt  = (fixed == bin_norm_pkg::PIX_BLACK) ? bin_norm_pkg::PIX_WHITE
                                                          : bin_norm_pkg::PIX_BLACK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= info.valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_r  <= pixel_nxt;
    status_r <= status_nxt;
    last_r   <= info.last;
  end

  assign out_valid     = valid_r;
  assign out_pixel_out = pixel_r;
  assign out_status    = status_r;
  assign out_last      = last_r;

endmodule

@@ rtl/binarized_image_normalizer.sv @@
// ----------------------------------------------------------------------------
// Binarized image normalizer
// Stores a grayscale frame, then plays it back cleaned to black and white.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction with start high while busy is low. in_mode low loads
//   in_pixel into the frame store in raster order (in_frame_start on the
//   first load clears counts and positions); loads produce no result.
//   in_mode high reads the next processed pixel in raster order.
//   Each read's result passes the registered read of the frame store and
//   then the fix-up register: out_valid is high for one cycle with
//   out_pixel_out, out_status and out_last.
//   Throughput is one transaction per cycle while busy is low.
//   The receiver cannot stall; results are never held back.
//   Configuration: pulse cfg_we with cfg_index and cfg_wdata, only while no
//   read result is outstanding.
//   Reset (rst_n low, synchronous) restores the register defaults, clears
//   counts and positions and holds busy high until the cycle after release.
//   The frame store is not cleared; read only pixels that were loaded.
// ----------------------------------------------------------------------------
module binarized_image_normalizer #(
  parameter int MAX_WIDTH  = bin_norm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bin_norm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [bin_norm_pkg::PIX_W-1:0]      in_pixel,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  output logic [bin_norm_pkg::PIX_W-1:0]      out_pixel_out,
  output logic [bin_norm_pkg::STATUS_W-1:0]   out_status,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [bin_norm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bin_norm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic                           busy_r;
  logic                           accept;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [bin_norm_pkg::PIX_W-1:0] ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [bin_norm_pkg::PIX_W-1:0] ram_rdata;
  bin_norm_pkg::rd_info_t         info;

  // Hold off transactions while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  bin_norm_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_mode        (in_mode),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .info           (info)
  );

  bin_norm_ram #(
    .WIDTH (bin_norm_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bin_norm_fix u_fix (
    .clk           (clk),
    .rst_n         (rst_n),
    .info          (info),
    .rd_pixel      (ram_rdata),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule

@@ test/bin_norm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binarized image normalizer checker
// Watches the command, result and register ports. It keeps its own frame
// store, pixel counts and read position, predicts each read result, and
// compares each result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package bin_norm_tb_pkg;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

endpackage

module bin_norm_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                in_mode,
  input  logic [bin_norm_pkg::PIX_W-1:0]      in_pixel,
  input  logic                                in_frame_start,
  input  logic                                out_valid,
  input  logic [bin_norm_pkg::PIX_W-1:0]      out_pixel_out,
  input  logic [bin_norm_pkg::STATUS_W-1:0]   out_status,
  input  logic                                out_last,
  input  logic                                cfg_we,
  input  logic [bin_norm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bin_norm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  outstanding,
  output int                                  mismatches
);

  import bin_norm_pkg::*;
  import bin_norm_tb_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic [STATUS_W-1:0] status;
    logic                last;
  } norm_pixel_t;

  logic [PIX_W-1:0]     frame_mem [STORE_DEPTH];
  norm_pixel_t          pixel_results [$];

  int unsigned          black_tally;
  int unsigned          white_tally;
  int unsigned          gray_count;
  int unsigned          load_pos;
  int unsigned          read_col;
  int unsigned          read_row;

  logic [DIM_CFG_W-1:0] width_reg;
  logic [DIM_CFG_W-1:0] height_reg;
  logic [GAP_W-1:0]     gap_reg;
  logic [PIX_W-1:0]     threshold_reg;
  logic [RATIO_W-1:0]   ratio_reg;

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Zero acts as one, oversize clamps to the store geometry
  function automatic int unsigned active_dim(input logic [DIM_CFG_W-1:0] d,
                                             input int unsigned cap);
    if (d == 0) return 1;
    if (d > cap) return cap;
    return d;
  endfunction

  task automatic store_pixel(input logic [PIX_W-1:0] pix, input logic restart);
    int unsigned total;
    total = active_dim(width_reg, MAX_WIDTH_DEF) * active_dim(height_reg, MAX_HEIGHT_DEF);
    if (restart) begin
      black_tally = 0;
      white_tally = 0;
      gray_count  = 0;
      load_pos    = 0;
      read_col    = 0;
      read_row    = 0;
    end
    // Loads past the end of the frame are dropped until the next frame start
    if (load_pos < total) begin
      frame_mem[load_pos] = pix;
      if (pix == PIX_BLACK) black_tally++;
      else if (pix == PIX_WHITE) white_tally++;
      else gray_count++;
      load_pos++;
    end
  endtask

  task automatic predict_read(output norm_pixel_t res);
    int unsigned       w;
    int unsigned       h;
    int unsigned       x;
    int unsigned       y;
    longint unsigned   bw_weight;
    longint unsigned   gray_weight;
    logic [PIX_W-1:0]  v;
    logic              inner;
    w = active_dim(width_reg, MAX_WIDTH_DEF);
    h = active_dim(height_reg, MAX_HEIGHT_DEF);
    // Restart at the origin when the dimensions shrank under the position
    if (read_col >= w || read_row >= h) begin
      read_col = 0;
      read_row = 0;
    end
    x = read_col;
    y = read_row;
    v = frame_mem[y * w + x];
    bw_weight   = longint'(black_tally + white_tally) << 8;
    gray_weight = longint'(ratio_reg) * longint'(gray_count);
    if (gray_weight < bw_weight) begin
      if (v != PIX_BLACK && v != PIX_WHITE) begin
        inner = x > gap_reg && y > gap_reg && x + gap_reg < w && y + gap_reg < h;
        v = (inner && v < threshold_reg) ? PIX_BLACK : PIX_WHITE;
      end
      if (longint'(black_tally) > 2 * longint'(white_tally)) begin
        if (white_tally == 0) begin
          res.status = ST_WRONG;
        end else begin
          res.status = ST_INVERTED;
          v = (v == PIX_BLACK) ? PIX_WHITE : PIX_BLACK;
        end
      end else begin
        res.status = ST_KEPT;
      end
    end else begin
      res.status = ST_UNCHANGED;
    end
    res.pixel = v;
    res.last  = (x + 1 == w) && (y + 1 == h);
    if (x + 1 < w) begin
      read_col = x + 1;
    end else begin
      read_col = 0;
      read_row = res.last ? 0 : y + 1;
    end
  endtask

  always @(posedge clk) begin : monitor
    norm_pixel_t want;
    norm_pixel_t fresh;
    if (!rst_n) begin
      black_tally   = 0;
      white_tally   = 0;
      gray_count    = 0;
      load_pos      = 0;
      read_col      = 0;
      read_row      = 0;
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      gap_reg       = GAP_RST;
      threshold_reg = THRESHOLD_RST;
      ratio_reg     = RATIO_RST;
    end else begin
      if (out_valid) begin
        if (pixel_results.size() == 0) begin
          log_mismatch($sformatf("result with no read outstanding: pixel %0d status %0d last %0b",
                                 out_pixel_out, out_status, out_last));
        end else begin
          want = pixel_results.pop_front();
          if (out_pixel_out !== want.pixel)
            log_mismatch($sformatf("pixel_out %0d, predicted %0d", out_pixel_out, want.pixel));
          if (out_status !== want.status)
            log_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
          if (out_last !== want.last)
            log_mismatch($sformatf("last %0b, predicted %0b", out_last, want.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:    width_reg     = cfg_wdata[DIM_CFG_W-1:0];
          CFG_FRAME_HEIGHT:   height_reg    = cfg_wdata[DIM_CFG_W-1:0];
          CFG_FRAME_GAP:      gap_reg       = cfg_wdata[GAP_W-1:0];
          CFG_GRAY_THRESHOLD: threshold_reg = cfg_wdata[PIX_W-1:0];
          CFG_NONBW_RATIO:    ratio_reg     = cfg_wdata[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_mode == MODE_READ) begin
          predict_read(fresh);
          pixel_results.push_back(fresh);
        end else begin
          store_pixel(in_pixel, in_frame_start);
        end
      end
    end
    outstanding <= pixel_results.size();
  end

endmodule

@@ test/tb_binarized_image_normalizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binarized image normalizer testbench
// Loads frames of varied geometry and pixel mix, reads them back with random
// sender gaps, and leaves prediction and comparison to the checker beside
// the block. A short directed frame comes first, then random phases.
// ----------------------------------------------------------------------------
module tb_binarized_image_normalizer;

  import bin_norm_pkg::*;
  import bin_norm_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 450;
  // Longest frame head loaded in one phase; the reads of a phase stay below
  localparam int unsigned LOAD_CAP = 32;
  // Directed 3x3 frame, first pixel in the low byte
  localparam logic [71:0] SEED_FRAME = {8'd0, 8'd255, 8'd255, 8'd128, 8'd127,
                                        8'd254, 8'd1, 8'd255, 8'd0};

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_mode;
  logic [PIX_W-1:0]      in_pixel;
  logic                  in_frame_start;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel_out;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int sender_idle_pct;
  int black_pct;
  int white_pct;

  binarized_image_normalizer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  bin_norm_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_pixel_out  (out_pixel_out),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .outstanding    (outstanding),
    .mismatches     (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_binarized_image_normalizer: errors");
      $finish;
    end
  end

  function automatic int unsigned active_dim(input logic [DIM_CFG_W-1:0] d,
                                             input int unsigned cap);
    if (d == 0) return 1;
    if (d > cap) return cap;
    return d;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    int r;
    r = $urandom_range(99);
    if (r < black_pct) return PIX_BLACK;
    if (r < black_pct + white_pct) return PIX_WHITE;
    return PIX_W'($urandom_range(1, 254));
  endfunction

  // Hold the transaction until the block takes it
  task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix, input logic fs);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_pixel       <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending until every read result is back, then let the pipe empty
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input logic [DIM_CFG_W-1:0] w,
                                   input logic [DIM_CFG_W-1:0] h,
                                   input logic [GAP_W-1:0]     gap,
                                   input logic [PIX_W-1:0]     thr,
                                   input logic [RATIO_W-1:0]   ratio);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx[0] = CFG_FRAME_WIDTH;
    idx[1] = CFG_FRAME_HEIGHT;
    idx[2] = CFG_FRAME_GAP;
    idx[3] = CFG_GRAY_THRESHOLD;
    idx[4] = CFG_NONBW_RATIO;
    // Junk above each narrower register's width must be dropped
    val[0] = {6'($urandom), w};
    val[1] = {6'($urandom), h};
    val[2] = {7'($urandom), gap};
    val[3] = {8'($urandom), thr};
    val[4] = ratio;
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned          extent;
    int unsigned          frame_total;
    int unsigned          load_count;
    int                   mixed_items;
    int                   phase_idx;
    int                   r;
    logic                 reload;
    logic [DIM_CFG_W-1:0] w;
    logic [DIM_CFG_W-1:0] h;
    logic [GAP_W-1:0]     gap;
    logic [PIX_W-1:0]     thr;
    logic [RATIO_W-1:0]   ratio;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_LOAD;
    in_pixel        = '0;
    in_frame_start  = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FRAME_WIDTH;
    cfg_wdata       = '0;
    sender_idle_pct = 27;
    black_pct       = 30;
    white_pct       = 30;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed frame: extreme pixels, a gray pixel on each side of the
    // threshold inside the margin, a load past the end, a frame start on a
    // read, and a read-back that wraps around
    program_registers(10'd3, 10'd3, 9'd0, 8'd128, 16'd256);
    for (int i = 0; i < 9; i++) send_item(MODE_LOAD, SEED_FRAME[8*i +: 8], i == 0);
    send_item(MODE_LOAD, PIX_BLACK, 1'b0);
    for (int i = 0; i < 11; i++) send_item(MODE_READ, PIX_WHITE, i == 4);
    extent = 9;

    mixed_items = 0;
    phase_idx   = 0;
    while (mixed_items < RANDOM_ITEMS) begin
      case (phase_idx)
        0: begin w = 10'd1023; h = 10'd1;    gap = 9'd0;   thr = 8'd255; ratio = 16'd0;     end
        1: begin w = 10'd1;    h = 10'd1023; gap = 9'd511; thr = 8'd0;   ratio = 16'hFFFF; end
        2: begin w = 10'd0;    h = 10'd0;    gap = 9'd0;   thr = 8'd255; ratio = 16'hFFFF; end
        3: begin w = 10'd512;  h = 10'd2;    gap = 9'd511; thr = 8'd0;   ratio = 16'd0;     end
        default: begin
          w   = ($urandom_range(99) < 8) ? 10'd0 : 10'($urandom_range(1, 12));
          h   = ($urandom_range(99) < 8) ? 10'd0 : 10'($urandom_range(1, 10));
          gap = ($urandom_range(99) < 10) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 4));
          thr = 8'($urandom_range(0, 255));
          case ($urandom_range(3))
            0:       ratio = 16'd256;
            1:       ratio = 16'($urandom_range(0, 1023));
            2:       ratio = 16'($urandom_range(0, 65535));
            default: ratio = 16'd64;
          endcase
        end
      endcase
      case ($urandom_range(3))
        0:       begin black_pct = 20; white_pct = 70; end
        1:       begin black_pct = 70; white_pct = 20; end
        2:       begin black_pct = 80; white_pct = 0;  end
        default: begin black_pct = 10; white_pct = 10; end
      endcase
      frame_total = active_dim(w, MAX_WIDTH_DEF) * active_dim(h, MAX_HEIGHT_DEF);
      // Without a fresh load, reads must stay on pixels already written
      reload = frame_total > extent || $urandom_range(99) < 70;
      program_registers(w, h, gap, thr, ratio);
      sender_idle_pct = (mixed_items < 150) ? 27 : ((mixed_items < 300) ? 51 : 0);
      if (reload) begin
        // Load only the head of a large frame
        load_count = (frame_total > LOAD_CAP) ? LOAD_CAP
                                              : frame_total + $urandom_range(0, 2);
        for (int unsigned i = 0; i < load_count; i++) begin
          send_item(MODE_LOAD, draw_pixel(), i == 0);
          mixed_items++;
        end
        if (load_count > frame_total) load_count = frame_total;
        if (load_count > extent) extent = load_count;
      end
      repeat ($urandom_range(12, 30)) begin
        sender_idle_pct = (mixed_items < 150) ? 27 : ((mixed_items < 300) ? 51 : 0);
        r = $urandom_range(99);
        if (r < 70) begin
          send_item(MODE_READ, PIX_W'($urandom), 1'b0);
        end else if (r < 86) begin
          send_item(MODE_LOAD, draw_pixel(), 1'b0);
        end else if (r < 92) begin
          send_item(MODE_LOAD, draw_pixel(), 1'b1);
        end else if (r < 95) begin
          wait_drained();
        end else begin
          send_item(MODE_READ, PIX_W'($urandom), 1'b1);
        end
        mixed_items++;
      end
      phase_idx++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_binarized_image_normalizer: clean");
    end else begin
      $display("tb_binarized_image_normalizer: errors");
    end
    $finish;
  end

endmodule
